// File: hw/rtl/wsdg_pkg.sv
// Shared constants for the window standard-deviation stability gate.
// Field widths, register reset values and configuration register indexes.
// No dependencies.
`default_nettype none

package wsdg_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int LIMIT_W    = 12;
  localparam int RUNS_W     = 8;
  localparam int SUM_W      = 20;
  localparam int SQSUM_W    = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 8;

  localparam int WINDOW_LENGTH_DEF = 150;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd190;
  localparam logic [RUNS_W-1:0]  RUNS_RESET  = 8'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEVIATION_LIMIT    = 1'b0,
    REG_STABLE_RUNS_NEEDED = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: hw/rtl/window_stddev_stability_gate_unit.sv
// Window standard-deviation stability gate, top level.
// Depends on wsdg_pkg and wsdg_ram.
//
// Usage:
//   Samples enter on the s_ stream (s_tdata[11:0]); one stable flag per sample
//   leaves on the m_ stream (m_tdata[0]). Each sample replaces the oldest of the
//   last WINDOW_LENGTH samples; the flag is 1 once enough consecutive windows
//   had a standard deviation strictly below deviation_limit.
//   Configuration: cfg_we with cfg_addr 0 writes deviation_limit, cfg_addr 1
//   writes stable_runs_needed; write only while no transaction is in flight.
//   Throughput: one sample per cycle while m_tready is high. m_tvalid rises
//   after the input transaction has passed a six-register pipeline: RAM read
//   of the oldest sample, squaring, running-sum update, wide products, compare,
//   and run counter with result register.
//   Reset (rst, synchronous) empties the pipeline, zeroes the sums, the run
//   counter and the window (through per-entry valid bits), and restores the
//   register defaults. When m_tready is low the pipeline fills its bubbles and
//   then holds; s_tready drops only when every stage is occupied.
`default_nettype none

module window_stddev_stability_gate_unit
  import wsdg_pkg::*;
#(
  parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // fields: sample [11:0], zero fill [15:12]
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // fields: stable [0], zero fill [7:1]
  output logic      [M_TDATA_W-1:0]  m_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(WINDOW_LENGTH);
  localparam int NW    = $clog2(WINDOW_LENGTH + 1);
  localparam int SQ_W  = 2 * SAMPLE_W;
  localparam int NL_W  = NW + LIMIT_W;
  localparam int CMP_W = 2 * SUM_W + 1;
  localparam logic [AW-1:0] LastSlot = AW'(WINDOW_LENGTH - 1);
  localparam logic [NW-1:0] NVal     = NW'(WINDOW_LENGTH);
  localparam logic [SUM_W-1:0] SumMax = SUM_W'(WINDOW_LENGTH * ((1 << SAMPLE_W) - 1));

  // Configuration registers and derived threshold
  logic [LIMIT_W-1:0] deviation_limit;
  logic [RUNS_W-1:0]  stable_runs_needed;
  logic [NL_W-1:0]    limit_scaled;
  logic [CMP_W-1:0]   limit_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      deviation_limit    <= LIMIT_RESET;
      stable_runs_needed <= RUNS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DEVIATION_LIMIT:    deviation_limit    <= cfg_wdata[LIMIT_W-1:0];
        REG_STABLE_RUNS_NEEDED: stable_runs_needed <= cfg_wdata[RUNS_W-1:0];
        default: ;
      endcase
    end
  end

  // N^2 * limit^2, registered through limit_scaled and then limit_term
  always_ff @(posedge clk) begin
    limit_scaled <= NL_W'(deviation_limit) * NL_W'(NVal);
    limit_term   <= CMP_W'(limit_scaled) * CMP_W'(limit_scaled);
  end

  // Pipeline flow control: a stage loads when it is empty or moving on
  logic v1, v2, v3, v4, v5;
  logic mv1, mv2, mv3, mv4, mv5;
  logic room1, room2, room3, room4, room5;
  logic accept;

  assign mv5   = v5 && (!m_tvalid || m_tready);
  assign room5 = !v5 || mv5;
  assign mv4   = v4 && room5;
  assign room4 = !v4 || mv4;
  assign mv3   = v3 && room4;
  assign room3 = !v3 || mv3;
  assign mv2   = v2 && room3;
  assign room2 = !v2 || mv2;
  assign mv1   = v1 && room2;
  assign room1 = !v1 || mv1;

  assign s_tready = room1;
  assign accept   = s_tvalid && room1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (room1) v1 <= accept;
      if (room2) v2 <= mv1;
      if (room3) v3 <= mv2;
      if (room4) v4 <= mv3;
      if (room5) v5 <= mv4;
      if (mv5) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Stage 1: overwrite the oldest slot, read back its old sample
  logic [AW-1:0]            write_slot;
  logic [WINDOW_LENGTH-1:0] slot_valid;
  logic [SAMPLE_W-1:0]      sample_in;
  logic [SAMPLE_W-1:0]      s1_sample;
  logic                     s1_old_valid;
  logic [SAMPLE_W-1:0]      ram_rdata;

  assign sample_in = s_tdata[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      slot_valid <= '0;
    end else if (accept) begin
      write_slot             <= (write_slot == LastSlot) ? '0 : write_slot + AW'(1);
      slot_valid[write_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample    <= sample_in;
      s1_old_valid <= slot_valid[write_slot];
    end
  end

  wsdg_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LENGTH)
  ) u_window (
    .clk   (clk),
    .en    (accept),
    .we    (accept),
    .addr  (write_slot),
    .wdata (sample_in),
    .rdata (ram_rdata)
  );

  // Stage 2: squares of the entering and leaving samples
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] s2_sample;
  logic [SAMPLE_W-1:0] s2_old;
  logic [SQ_W-1:0]     s2_sample_sq;
  logic [SQ_W-1:0]     s2_old_sq;

  assign old_sample = s1_old_valid ? ram_rdata : '0;

  always_ff @(posedge clk) begin
    if (mv1) begin
      s2_sample    <= s1_sample;
      s2_old       <= old_sample;
      s2_sample_sq <= SQ_W'(s1_sample) * SQ_W'(s1_sample);
      s2_old_sq    <= SQ_W'(old_sample) * SQ_W'(old_sample);
    end
  end

  // Stage 3: running sums
  logic [SUM_W-1:0]   running_sum;
  logic [SQSUM_W-1:0] running_square_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum        <= '0;
      running_square_sum <= '0;
    end else if (mv2) begin
      running_sum        <= running_sum - SUM_W'(s2_old) + SUM_W'(s2_sample);
      running_square_sum <= running_square_sum - SQSUM_W'(s2_old_sq)
                            + SQSUM_W'(s2_sample_sq);
    end
  end

  // Stage 4: N*sumsq and sum^2
  logic [CMP_W-1:0] s4_lhs;
  logic [CMP_W-1:0] s4_sum_sq;

  always_ff @(posedge clk) begin
    if (mv3) begin
      s4_lhs    <= CMP_W'(running_square_sum) * CMP_W'(NVal);
      s4_sum_sq <= CMP_W'(running_sum) * CMP_W'(running_sum);
    end
  end

  // Stage 5: variance test, lhs - sum^2 < limit term (negative variance as zero)
  logic s5_pass;

  always_ff @(posedge clk) begin
    if (mv4) begin
      s5_pass <= (s4_lhs < (s4_sum_sq + limit_term)) && (limit_term != '0);
    end
  end

  // Output stage: run counter and stable flag
  logic [RUNS_W-1:0] stable_run_count;
  logic [RUNS_W-1:0] stable_run_count_next;
  logic              stable;

  always_comb begin
    if (!s5_pass) begin
      stable_run_count_next = '0;
    end else if (stable_run_count == '1) begin
      stable_run_count_next = stable_run_count;
    end else begin
      stable_run_count_next = stable_run_count + RUNS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_run_count <= '0;
    end else if (mv5) begin
      stable_run_count <= stable_run_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mv5) begin
      stable <= (stable_run_count_next >= stable_runs_needed);
    end
  end

  assign m_tdata = {(M_TDATA_W - 1)'(0), stable};

  // Checks
  a_sum_bounded: assert property (@(posedge clk) disable iff (rst)
    running_sum <= SumMax)
    else $error("running sum exceeds window capacity");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= LastSlot)
    else $error("write slot out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4 && v5 && m_tvalid))
    else $error("input stalled with a bubble in the pipeline");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    (mv5 && s5_pass && stable_run_count == '1) |=> stable_run_count == '1)
    else $error("run counter wrapped");

  a_flag_match: assert property (@(posedge clk) disable iff (rst)
    mv5 |=> stable == (stable_run_count >= $past(stable_runs_needed)))
    else $error("stable flag disagrees with run counter");

endmodule

`default_nettype wire

// File: hw/rtl/wsdg_ram.sv
// Generic single-port RAM with registered read, read-before-write.
// Used for the sample window store. No dependencies.
`default_nettype none

module wsdg_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 150
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for window_stddev_stability_gate_unit: streams 12-bit samples, predicts each
// stable flag from a local copy of the window, running sums and run counter, checks results.
// Depends on wsdg_pkg and the unit's RTL.

module tb
  import wsdg_pkg::*;
;

  localparam int WIN_LEN         = WINDOW_LENGTH_DEF;
  localparam int DRAIN_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = REG_DEVIATION_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Local copy of the window state and registers
  logic [SAMPLE_W-1:0] win_samples [WIN_LEN];
  int unsigned         win_slot;
  logic [SUM_W-1:0]    win_sum;
  logic [SQSUM_W-1:0]  win_sqsum;
  logic [7:0]          run_count;
  logic [LIMIT_W-1:0]  dev_limit;
  logic [RUNS_W-1:0]   runs_needed;

  bit expected_stable_q [$];
  int errors      = 0;
  int cycles      = 0;
  bit tx_gaps_on  = 1'b0;
  bit rx_gaps_on  = 1'b0;
  int rx_hold_len = 0;

  window_stddev_stability_gate_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic bit predict_stable_flag(input logic [SAMPLE_W-1:0] smp);
    logic [SAMPLE_W-1:0] oldest;
    logic [63:0]         lhs;
    logic [63:0]         sq;
    logic [63:0]         spread;
    logic [63:0]         bound;
    oldest = win_samples[win_slot];
    win_samples[win_slot] = smp;
    win_slot = (win_slot + 1 >= WIN_LEN) ? 0 : win_slot + 1;
    win_sum = win_sum - SUM_W'(oldest) + SUM_W'(smp);
    win_sqsum = win_sqsum - SQSUM_W'(oldest) * SQSUM_W'(oldest)
                + SQSUM_W'(smp) * SQSUM_W'(smp);
    // N*sumsq - sum^2 < N^2*limit^2 stands in for stddev < limit
    lhs    = 64'(WIN_LEN) * 64'(win_sqsum);
    sq     = 64'(win_sum) * 64'(win_sum);
    spread = (lhs > sq) ? lhs - sq : 64'd0;
    bound  = 64'(WIN_LEN * WIN_LEN) * 64'(dev_limit) * 64'(dev_limit);
    if (spread < bound) begin
      if (run_count != 8'd255) run_count = run_count + 8'd1;
    end else begin
      run_count = '0;
    end
    return run_count >= runs_needed;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_TDATA_W'(smp);
    do @(posedge clk); while (!s_tready);
    expected_stable_q.push_back(predict_stable_flag(smp));
  endtask

  // Drop valid, then wait until every flag has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_stable_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEVIATION_LIMIT:    dev_limit   = val[LIMIT_W-1:0];
      REG_STABLE_RUNS_NEEDED: runs_needed = val[RUNS_W-1:0];
      default: ;
    endcase
  endtask

  // Early windows still hold reset zeros; extremes and single bits of the sample
  task automatic test_directed_samples();
    logic [SAMPLE_W-1:0] pattern [$];
    pattern = '{12'd0, 12'd0, 12'hFFF, 12'd0, 12'hAAA, 12'h555, 12'hFFF, 12'hFFE};
    for (int k = 0; k < SAMPLE_W; k++) pattern.push_back(SAMPLE_W'(1) << k);
    foreach (pattern[i]) send_sample(pattern[i]);
  endtask

  task automatic test_limit_extremes();
    wait_drained();
    write_reg(REG_DEVIATION_LIMIT, '0);
    send_sample(12'd0);
    send_sample(12'd0);
    repeat (2) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
    wait_drained();
    write_reg(REG_STABLE_RUNS_NEEDED, '0);
    repeat (3) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
  endtask

  // Widest limit makes every window stable, so the counter climbs to its ceiling
  task automatic test_counter_saturation();
    wait_drained();
    write_reg(REG_DEVIATION_LIMIT, 12'hFFF);
    write_reg(REG_STABLE_RUNS_NEEDED, CFG_DATA_W'(255));
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b0;
    rx_hold_len = HOLD_OFF_CYCLES;
    repeat (150) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
    wait_drained();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (150) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
  endtask

  // Runs of samples jittered around a base, then a noise burst to break the run
  task automatic test_settling_sequences();
    int base;
    int amp;
    int len;
    int val;
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      write_reg(REG_DEVIATION_LIMIT, CFG_DATA_W'($urandom_range(8, 400)));
      write_reg(REG_STABLE_RUNS_NEEDED,
                CFG_DATA_W'(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 60)));
      tx_gaps_on = 1'($urandom_range(0, 1));
      rx_gaps_on = 1'($urandom_range(0, 1));
      base = $urandom_range(0, 4095);
      amp  = $urandom_range(0, 2 * int'(dev_limit));
      len  = $urandom_range(170, 230);
      repeat (len) begin
        val = base + int'($urandom_range(0, 2 * amp)) - amp;
        if (val < 0) val = 0;
        if (val > 4095) val = 4095;
        send_sample(SAMPLE_W'(val));
      end
      repeat ($urandom_range(1, 20)) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
    end
  endtask

  initial begin : result_receiver
    int gap;
    wait (!rst);
    forever begin
      // Long hold-off: let the pipeline fill and stall the input side
      if (rx_hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end
      gap = rx_gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin : result_check
    bit want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_stable_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: unexpected transaction, stable=%0b", m_tdata[0]);
      end else begin
        want = expected_stable_q.pop_front();
        if (m_tdata[0] !== want) begin
          errors++;
          if (errors <= 10)
            $display("tb: stable mismatch, expected %0b, got %0b", want, m_tdata[0]);
        end
      end
    end
  end

  initial begin : main_sequence
    for (int i = 0; i < WIN_LEN; i++) win_samples[i] = '0;
    win_slot    = 0;
    win_sum     = '0;
    win_sqsum   = '0;
    run_count   = '0;
    dev_limit   = LIMIT_RESET;
    runs_needed = RUNS_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_directed_samples();
    test_limit_extremes();
    test_counter_saturation();
    test_settling_sequences();
    wait_drained();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/wsdg_pkg.sv
hw/rtl/wsdg_ram.sv
hw/rtl/window_stddev_stability_gate_unit.sv
sim/tb.sv
